@@ sv/adc_lid_pkg.sv @@
// Shared constants and types for the ADC ladder module-id debounce block.
`timescale 1ns / 1ps

package adc_lid_pkg;

  // Sample and register widths
  localparam int SAMPLE_BITS   = 12;
  localparam int CENTER_BITS   = 12;
  localparam int TOL_BITS      = 12;
  localparam int RUN_BITS      = 4;
  localparam int ID_BITS       = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;

  // Lookup table size: only the first SEARCH_ENTRIES slots are searched
  localparam int TABLE_ENTRIES  = 4;
  localparam int CENTER_SLOTS   = 4;
  localparam int SEARCH_ENTRIES = (TABLE_ENTRIES < CENTER_SLOTS) ? TABLE_ENTRIES : CENTER_SLOTS;

  // Difference width covers both the sample and the centers
  localparam int DIFF_BITS = (SAMPLE_BITS > CENTER_BITS) ? SAMPLE_BITS : CENTER_BITS;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_LED_RING     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_WIFI_CAMERA  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_OPTICAL_FLOW = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_RESERVED     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MATCH_TOLERANCE     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_COUNT       = 3'd5;

  // Register reset values
  localparam logic [CENTER_BITS-1:0] RST_CENTER_LED_RING     = 12'd2048;
  localparam logic [CENTER_BITS-1:0] RST_CENTER_WIFI_CAMERA  = 12'd4095;
  localparam logic [CENTER_BITS-1:0] RST_CENTER_OPTICAL_FLOW = 12'd2815;
  localparam logic [CENTER_BITS-1:0] RST_CENTER_RESERVED     = 12'd1280;
  localparam logic [TOL_BITS-1:0]    RST_MATCH_TOLERANCE     = 12'd50;
  localparam logic [RUN_BITS-1:0]    RST_CONFIRM_COUNT       = 4'd3;

  // Module id codes
  localparam logic [ID_BITS-1:0] ID_NONE = 3'd0;

  typedef logic [CENTER_SLOTS-1:0][CENTER_BITS-1:0] center_arr_t;

endpackage

@@ sv/adc_lid_classify.sv @@
// Window compare of one sample against the center table; first hit wins.
`timescale 1ns / 1ps

module adc_lid_classify (
  input  logic [adc_lid_pkg::SAMPLE_BITS-1:0] sample,
  input  adc_lid_pkg::center_arr_t            centers,
  input  logic [adc_lid_pkg::TOL_BITS-1:0]    tolerance,
  output logic [adc_lid_pkg::ID_BITS-1:0]     id
);
  import adc_lid_pkg::*;

  // Scan from the last entry down so the lowest matching entry is kept
  always_comb begin
    logic [DIFF_BITS-1:0] s;
    logic [DIFF_BITS-1:0] c;
    logic [DIFF_BITS-1:0] d;
    logic [DIFF_BITS-1:0] t;
    s  = DIFF_BITS'(sample);
    t  = DIFF_BITS'(tolerance);
    id = ID_NONE;
    for (int k = SEARCH_ENTRIES - 1; k >= 0; k--) begin
      c = DIFF_BITS'(centers[k]);
      d = (s > c) ? (s - c) : (c - s);
      if (d <= t) begin
        id = ID_BITS'(k + 1);
      end
    end
  end

endmodule

@@ sv/adc_lid_debounce.sv @@
// Run counter, swap decision and power rail state for the matched id.
`timescale 1ns / 1ps

module adc_lid_debounce (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic [adc_lid_pkg::ID_BITS-1:0]  id,
  input  logic [adc_lid_pkg::RUN_BITS-1:0] confirm,
  output logic [adc_lid_pkg::ID_BITS-1:0]  active_next,
  output logic [adc_lid_pkg::ID_BITS-1:0]  active_now,
  output logic                             swap,
  output logic                             power_next,
  output logic [adc_lid_pkg::RUN_BITS-1:0] run_next
);
  import adc_lid_pkg::*;

  logic [ID_BITS-1:0]  active_module_id;
  logic [ID_BITS-1:0]  candidate_id;
  logic [ID_BITS-1:0]  candidate_id_next;
  logic [RUN_BITS-1:0] match_run;
  logic                power_rail;

  // Count consecutive equal ids, saturating at the confirm threshold
  always_comb begin
    if (id == candidate_id) begin
      candidate_id_next = candidate_id;
      run_next = (match_run < confirm) ? match_run + 1'b1 : match_run;
    end else begin
      candidate_id_next = id;
      run_next = '0;
    end
    swap        = (run_next >= confirm) && (id != active_module_id);
    active_next = swap ? id : active_module_id;
    power_next  = swap ? (id != ID_NONE) : power_rail;
  end

  assign active_now = active_module_id;

  // State commits once per transferred sample
  always_ff @(posedge clk) begin
    if (rst) begin
      active_module_id <= ID_NONE;
      candidate_id     <= ID_NONE;
      match_run        <= '0;
      power_rail       <= 1'b0;
    end else if (step) begin
      active_module_id <= active_next;
      candidate_id     <= candidate_id_next;
      match_run        <= run_next;
      power_rail       <= power_next;
    end
  end

endmodule

@@ sv/adc_ladder_id_debounce_core.sv @@
// Top level: config registers, input register, classify, debounce, result register.
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    adc_sample
// out      output     out_valid / out_stall  matched_id active_id swap_now previous_id
//                                            power_enable stable_count
// cfg      input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// A sample passes the input and result registers; one per cycle if out_stall is low.
// Path: input register, window compare and run counter, result register.
// Synchronous reset restores register defaults and clears id, run and power state.
// An output stall holds the result; a sample already in the input register then
// stalls the input. cfg_ready is always high.

module adc_ladder_id_debounce_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [adc_lid_pkg::SAMPLE_BITS-1:0]   adc_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [adc_lid_pkg::ID_BITS-1:0]       matched_id,
  output logic [adc_lid_pkg::ID_BITS-1:0]       active_id,
  output logic                                  swap_now,
  output logic [adc_lid_pkg::ID_BITS-1:0]       previous_id,
  output logic                                  power_enable,
  output logic [adc_lid_pkg::RUN_BITS-1:0]      stable_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [adc_lid_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [adc_lid_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import adc_lid_pkg::*;

  center_arr_t          centers;
  logic [TOL_BITS-1:0]  match_tolerance;
  logic [RUN_BITS-1:0]  confirm_count;

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   advance;
  logic [ID_BITS-1:0]     id;
  logic [ID_BITS-1:0]     active_next;
  logic [ID_BITS-1:0]     active_now;
  logic                   swap;
  logic                   power_next;
  logic [RUN_BITS-1:0]    run_next;

  // Config register file; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centers[0]      <= RST_CENTER_LED_RING;
      centers[1]      <= RST_CENTER_WIFI_CAMERA;
      centers[2]      <= RST_CENTER_OPTICAL_FLOW;
      centers[3]      <= RST_CENTER_RESERVED;
      match_tolerance <= RST_MATCH_TOLERANCE;
      confirm_count   <= RST_CONFIRM_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CENTER_LED_RING:     centers[0]      <= CENTER_BITS'(cfg_data);
        REG_CENTER_WIFI_CAMERA:  centers[1]      <= CENTER_BITS'(cfg_data);
        REG_CENTER_OPTICAL_FLOW: centers[2]      <= CENTER_BITS'(cfg_data);
        REG_CENTER_RESERVED:     centers[3]      <= CENTER_BITS'(cfg_data);
        REG_MATCH_TOLERANCE:     match_tolerance <= TOL_BITS'(cfg_data);
        REG_CONFIRM_COUNT:       confirm_count   <= cfg_data[RUN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign advance  = !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= adc_sample;
    end
  end

  adc_lid_classify u_classify (
    .sample    (s1_sample),
    .centers   (centers),
    .tolerance (match_tolerance),
    .id        (id)
  );

  adc_lid_debounce u_debounce (
    .clk         (clk),
    .rst         (rst),
    .step        (s1_valid && advance),
    .id          (id),
    .confirm     (confirm_count),
    .active_next (active_next),
    .active_now  (active_now),
    .swap        (swap),
    .power_next  (power_next),
    .run_next    (run_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      matched_id   <= id;
      active_id    <= active_next;
      swap_now     <= swap;
      previous_id  <= swap ? active_now : active_next;
      power_enable <= power_next;
      stable_count <= run_next;
    end
  end

  // Checks on result consistency
  a_swap_changes_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && swap_now) |-> (active_id != previous_id))
    else $error("swap reported without a change of module id");

  a_swap_power: assert property (@(posedge clk) disable iff (rst)
    (out_valid && swap_now) |-> (power_enable == (active_id != ID_NONE)))
    else $error("power rail does not follow the new module id");

  a_no_swap_prev: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !swap_now) |-> (previous_id == active_id))
    else $error("previous id differs from active id without a swap");

  a_swap_takes_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && swap_now) |-> (active_id == matched_id))
    else $error("swap did not adopt the matched id");

endmodule
